/* src/smpq_pkg.sv */
// shared types, codes and defaults for the sorted min priority queue
package smpq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_POLL = 2'd1;
  localparam logic [1:0] FUNC_PEEK = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic signed [DATA_W-1:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] least_value;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic rd_least;
    logic rd_prev;
    logic wr_shift;
    logic wr_new;
    logic take_least;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic is_read;
    logic full;
    logic empty;
    logic off_zero;
    logic greater;
  } stat_t;

endpackage

/* src/smpq_ram.sv */
// generic single write port, single read port ram with registered read
module smpq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/smpq_ctrl.sv */
// controller state machine for the sorted min priority queue
module smpq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  smpq_pkg::stat_t stat_i,
  output smpq_pkg::cmd_t  cmd_o
);
  import smpq_pkg::*;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StAddRd  = 6'b000010,
    StAddCmp = 6'b000100,
    StPkRd   = 6'b001000,
    StPkTake = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          priority if (stat_i.is_add && !stat_i.full) begin
            state_d = StAddRd;
          end else if (stat_i.is_read && !stat_i.empty) begin
            state_d = StPkRd;
          end else begin
            state_d = StDone;
          end
        end
      end
      StAddRd: begin
        if (stat_i.off_zero) begin
          cmd_o.wr_new = 1'b1;
          state_d = StDone;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d = StAddCmp;
        end
      end
      StAddCmp: begin
        // larger entries move up one place until the new value fits
        if (stat_i.greater) begin
          cmd_o.wr_shift = 1'b1;
          state_d = StAddRd;
        end else begin
          cmd_o.wr_new = 1'b1;
          state_d = StDone;
        end
      end
      StPkRd: begin
        cmd_o.rd_least = 1'b1;
        state_d = StPkTake;
      end
      StPkTake: begin
        cmd_o.take_least = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.ld_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

/* src/smpq_dp.sv */
// datapath: ring of sorted entries in ram, count, head pointer and result word
module smpq_dp #(
  parameter int unsigned Capacity = smpq_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smpq_pkg::in_word_t  in_word_i,
  input  smpq_pkg::cmd_t      cmd_i,
  output smpq_pkg::stat_t     stat_o,
  output smpq_pkg::out_word_t out_word_o
);
  import smpq_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned SW = CW + 1;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] off_q, off_d;
  logic [1:0] func_q;
  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] least_q;
  logic [1:0] status_q;
  out_word_t out_q;

  logic [SW-1:0] sum_cur, sum_prev, sum_next;
  logic [AW-1:0] pos_cur, pos_prev, head_next;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic in_add, in_read;

  // ring positions, the sum always stays below twice the capacity
  always_comb begin
    sum_cur = SW'(head_q) + SW'(off_q);
    sum_prev = sum_cur - SW'(1);
    sum_next = SW'(head_q) + SW'(1);
    pos_cur = (sum_cur >= SW'(Capacity)) ? AW'(sum_cur - SW'(Capacity)) : AW'(sum_cur);
    pos_prev = (sum_prev >= SW'(Capacity)) ? AW'(sum_prev - SW'(Capacity)) : AW'(sum_prev);
    head_next = (sum_next >= SW'(Capacity)) ? AW'(sum_next - SW'(Capacity)) : AW'(sum_next);
  end

  assign in_add = (in_word_i.func == FUNC_ADD);
  assign in_read = (in_word_i.func == FUNC_POLL) || (in_word_i.func == FUNC_PEEK);

  assign ram_we = cmd_i.wr_shift || cmd_i.wr_new;
  assign ram_waddr = pos_cur;
  assign ram_wdata = cmd_i.wr_shift ? ram_rdata : val_q;
  assign ram_raddr = cmd_i.rd_prev ? pos_prev : head_q;

  smpq_ram #(
    .Width(DATA_W),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    stat_o.is_add = in_add;
    stat_o.is_read = in_read;
    stat_o.full = (count_q == CW'(Capacity));
    stat_o.empty = (count_q == '0);
    stat_o.off_zero = (off_q == '0);
    stat_o.greater = ($signed(ram_rdata) > val_q);
  end

  always_comb begin
    count_d = count_q;
    head_d = head_q;
    off_d = off_q;
    if (cmd_i.capture) begin
      off_d = count_q;
    end
    if (cmd_i.wr_shift) begin
      off_d = off_q - CW'(1);
    end
    if (cmd_i.wr_new) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.take_least && (func_q == FUNC_POLL)) begin
      count_d = count_q - CW'(1);
      head_d = head_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q <= '0;
      off_q <= '0;
    end else begin
      count_q <= count_d;
      head_q <= head_d;
      off_q <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= in_word_i.func;
      val_q <= in_word_i.new_value;
      least_q <= '0;
      priority if (in_add && stat_o.full) begin
        status_q <= STATUS_FULL;
      end else if (in_read && stat_o.empty) begin
        status_q <= STATUS_EMPTY;
      end else begin
        status_q <= STATUS_OK;
      end
    end
    if (cmd_i.take_least) begin
      least_q <= $signed(ram_rdata);
    end
    if (cmd_i.ld_out) begin
      out_q.least_value <= least_q;
      out_q.entry_count <= COUNT_OUT_W'(count_q);
      out_q.status <= status_q;
    end
  end

  assign out_word_o = out_q;

endmodule

/* src/sorted_min_priority_queue.sv */
// Sorted min priority queue top level. One word is taken when the block is
// idle and gives one result word. Entries sit ascending in a ring in a ram
// with one write and one registered read port: peek and poll read the head
// entry and take it as the least value; add moves each stored entry greater
// than the new value up one place and writes the new value where it stops.
// Empty reads, adds on a full queue and unused codes go straight to the
// result. The output register lets a word be accepted while the last result
// still waits. Entry count reports the count modulo 32.
module sorted_min_priority_queue #(
  parameter int unsigned Capacity = smpq_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smpq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smpq_pkg::out_word_t out_word_o
);
  import smpq_pkg::*;

  cmd_t cmd;
  stat_t stat;

  smpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  smpq_dp #(
    .Capacity(Capacity)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_word_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_word_o(out_word_o)
  );

endmodule

/* bench/tb.sv */
// self-checking testbench for the sorted min priority queue
module tb;
  import smpq_pkg::*;

  localparam int unsigned Cap = CAPACITY_DEF;
  localparam int unsigned RandomWords = 400;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 2 * Cap + 8;
  localparam logic [1:0] FuncUnused = 2'd3;

  class queue_mirror;
    logic signed [DATA_W-1:0] entries [Cap];
    int unsigned stored;
    int unsigned failures;
    out_word_t awaited_words [$];

    function new();
      stored = 0;
      failures = 0;
    endfunction

    // update the mirrored store and queue up the word the block should return
    function void note_word(in_word_t w);
      out_word_t r;
      logic signed [DATA_W-1:0] v;
      int unsigned pos;
      int unsigned i;
      r = '0;
      v = w.new_value;
      case (w.func)
        FUNC_ADD: begin
          if (stored >= Cap) begin
            r.status = STATUS_FULL;
          end else begin
            pos = 0;
            while (pos < stored && entries[pos] < v) pos++;
            for (i = stored; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = v;
            stored++;
          end
        end
        FUNC_POLL, FUNC_PEEK: begin
          if (stored == 0) begin
            r.status = STATUS_EMPTY;
          end else begin
            r.least_value = entries[0];
            if (w.func == FUNC_POLL) begin
              for (i = 0; i + 1 < stored; i++) entries[i] = entries[i+1];
              stored--;
            end
          end
        end
        default: ;
      endcase
      r.entry_count = stored[COUNT_OUT_W-1:0];
      awaited_words.push_back(r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp;
      if (awaited_words.size() == 0) begin
        $error("unexpected word: least_value %0d entry_count %0d status %0d",
               got.least_value, got.entry_count, got.status);
        failures++;
        return;
      end
      exp = awaited_words.pop_front();
      if (got.least_value !== exp.least_value) begin
        $error("least_value: expected %0d, got %0d", exp.least_value, got.least_value);
        failures++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
        failures++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        failures++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited_words.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  queue_mirror mirror;
  int unsigned cycles = 0;
  int unsigned send_run;
  bit          send_idle;
  int unsigned recv_run;
  bit          recv_idle;

  sorted_min_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // mix of full range, tight clusters for duplicates, and the extremes
  function automatic logic signed [DATA_W-1:0] draw_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $signed($urandom_range(0, 15)) - 8;
      7:          v = {1'b1, {(DATA_W-1){1'b0}}} + $urandom_range(0, 3);
      8:          v = {1'b0, {(DATA_W-1){1'b1}}} - $urandom_range(0, 3);
      default:    v = ($urandom_range(0, 1) != 0) ? '0 : '1;
    endcase
    return v;
  endfunction

  task automatic send_word(input logic [1:0] func, input logic signed [DATA_W-1:0] value);
    in_word_t w;
    int unsigned gap;
    w.func = func;
    w.new_value = value;
    if (send_run == 0) begin
      send_run = $urandom_range(5, 40);
      send_idle = ($urandom_range(0, 3) != 0);
    end
    send_run--;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    mirror.note_word(w);
  endtask

  // receiver: random back-pressure, then take one word
  initial begin
    int unsigned n;
    out_stall_i <= 1'b1;
    recv_run = 0;
    @(posedge rst_ni);
    forever begin
      if (recv_run == 0) begin
        recv_run = $urandom_range(5, 40);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      recv_run--;
      n = recv_idle ? $urandom_range(0, 6) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      mirror.check_word(out_word_o);
    end
  end

  initial begin
    bit filling;
    int unsigned k;
    int unsigned pick;
    logic [1:0] func;
    mirror = new();
    send_run = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty reads and the unused code on an empty queue
    send_word(FUNC_PEEK, '1);
    send_word(FUNC_POLL, '0);
    send_word(FuncUnused, $urandom);
    // extremes, a duplicate, then fill up to capacity
    send_word(FUNC_ADD, {1'b0, {(DATA_W-1){1'b1}}});
    send_word(FUNC_ADD, {1'b1, {(DATA_W-1){1'b0}}});
    send_word(FUNC_ADD, '0);
    send_word(FUNC_ADD, '1);
    send_word(FUNC_ADD, '0);
    for (k = 5; k < Cap; k++) send_word(FUNC_ADD, draw_value());
    // add on a full queue is dropped
    send_word(FUNC_ADD, draw_value());
    send_word(FuncUnused, '1);
    send_word(FUNC_PEEK, $urandom);
    send_word(FUNC_POLL, $urandom);
    send_word(FUNC_POLL, $urandom);

    // random part swings between filling and draining so both ends get hit
    filling = 1'b0;
    for (k = 0; k < RandomWords; k++) begin
      if (mirror.stored >= Cap && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (mirror.stored == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      if ($urandom_range(0, 39) == 0) filling = ~filling;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        func = FuncUnused;
      end else if (filling) begin
        func = (pick < 75) ? FUNC_ADD : (pick < 90) ? FUNC_POLL : FUNC_PEEK;
      end else begin
        func = (pick < 70) ? FUNC_POLL : (pick < 85) ? FUNC_ADD : FUNC_PEEK;
      end
      send_word(func, draw_value());
    end
    in_valid_i <= 1'b0;

    while (mirror.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mirror.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/smpq_pkg.sv
src/smpq_ram.sv
src/smpq_ctrl.sv
src/smpq_dp.sv
src/sorted_min_priority_queue.sv
bench/tb.sv
